### hw/rtl/stereo_roi_point_statistics_top_assert.svh
// Assertion macros for the stereo ROI point statistics block.
`ifndef STEREO_ROI_POINT_STATISTICS_TOP_ASSERT_SVH
`define STEREO_ROI_POINT_STATISTICS_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SRPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define SRPS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/srps_pkg.sv
// Package with the types, constants and helpers of the ROI point statistics block.
package srps_pkg;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned CountBits = 24;
  localparam int unsigned SumBits   = 56;
  localparam int unsigned DivBits   = 56;
  localparam int unsigned DivCntBits = 6;
  localparam int unsigned MinPoints = 10;
  localparam logic signed [16:0] DispFloor = 17'sd32;

  localparam logic [2:0] CfgCx   = 3'd0;
  localparam logic [2:0] CfgCy   = 3'd1;
  localparam logic [2:0] CfgF    = 3'd2;
  localparam logic [2:0] CfgT    = 3'd3;
  localparam logic [2:0] CfgMind = 3'd4;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdDivX, CmdDivY, CmdDivZ, CmdAccum,
    CmdMeanZ, CmdMeanX, CmdMeanY, CmdMeanEnd, CmdClear
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic div_start;
  } ctrl_t;

  typedef struct packed {
    logic qualify;
    logic enough;
    logic div_busy;
  } stat_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
    if (v > 58'sd2147483647) return 32'sh7fffffff;
    if (v < -58'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### hw/rtl/stereo_roi_point_statistics_top.sv
// Top level of the stereo ROI point statistics block.
//  Channel | Direction | Content
//  s_axis  | in        | tdata: column, row, disparity; tlast: last_pixel
//  m_axis  | out       | tdata: extent_x, extent_y, mean_z, mean_x, mean_y, valid_res
//  cfg     | in        | register index and 16-bit value, one write per cycle
// A qualifying pixel holds the input through three 56-step divisions in the shared iterative
// divider; a non-qualifying pixel passes only through the check and wait states.
// The last pixel of a region adds three more divisions for the means, a clear and an output
// load; a region with too few points skips those divisions and adds only the clear and the load.
// Reset is asynchronous and clears configuration and accumulators.
// The result sits in an output register; a stall there holds only the next region end.
module stereo_roi_point_statistics_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata, // column, row, disparity
  input  logic         s_axis_tlast, // last_pixel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata  // extent_x, extent_y, mean_z, mean_x, mean_y, valid_res
);
  import srps_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [159:0] res;
  logic [160:0] out_q;
  logic in_fire, ok, snap;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  srps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready), .stat_i(stat), .ctrl_o(ctrl),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid), .out_ok_o(ok), .snap_o(snap)
  );

  srps_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .pix_i(s_axis_tdata),
    .ctrl_i(ctrl), .stat_o(stat), .res_o(res)
  );

  // Output register, loaded while the accumulators clear.
  always_ff @(posedge clk_i) begin
    if (snap) out_q <= {1'b1, res};
  end

  assign m_axis_tdata = ok ? {7'd0, out_q} : '0;

  `include "stereo_roi_point_statistics_top_assert.svh"

  `SRPS_ASSERT(a_no_in_while_busy, in_fire |=> !s_axis_tready, "input taken while busy")
  `SRPS_ASSERT(a_snap_idle_out, snap |-> !m_axis_tvalid || m_axis_tready, "result overwritten")
  `SRPS_ASSERT_NEVER(a_pad_zero, |m_axis_tdata[167:161], "tdata padding not zero")
endmodule

### hw/rtl/srps_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module srps_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [srps_pkg::DivBits-1:0] num_i,
  input  logic signed [srps_pkg::DivBits-1:0] den_i,
  output logic                                busy_o,
  output logic signed [srps_pkg::DivBits+1:0] quot_o
);
  import srps_pkg::*;

  logic [DivBits-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d;
  logic [DivBits:0] trial;

  // Restoring division on magnitudes.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q;
    trial = '0;
    if (start_i) begin
      quo_d  = num_i[DivBits-1] ? DivBits'(-num_i) : DivBits'(num_i);
      den_d  = den_i[DivBits-1] ? DivBits'(-den_i) : DivBits'(den_i);
      neg_d  = num_i[DivBits-1] ^ den_i[DivBits-1];
      rem_d  = '0;
      cnt_d  = DivCntBits'(DivBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[DivBits-1]} - {1'b0, den_q};
      if (!trial[DivBits]) begin
        rem_d = trial[DivBits-1:0];
        quo_d = {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivBits-2:0], quo_q[DivBits-1]};
        quo_d = {quo_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
endmodule

### hw/rtl/srps_datapath.sv
// Datapath: reprojection, accumulators and result registers.
module srps_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [39:0]           pix_i,
  input  srps_pkg::ctrl_t       ctrl_i,
  output srps_pkg::stat_t       stat_o,
  output logic [159:0]          res_o
);
  import srps_pkg::*;

  logic [15:0] cx_q, cy_q, f_q, t_q;
  logic signed [15:0] mind_q;
  logic [CoordBits-1:0] u_q, v_q;
  logic signed [15:0] d_q;
  logic signed [17:0] du, dv;
  logic signed [34:0] prod_q;
  logic signed [DivBits-1:0] num, den;
  logic signed [DivBits+1:0] quot;
  logic signed [31:0] px_q, py_q;
  logic [CountBits-1:0] cnt_q;
  logic signed [SumBits-1:0] sx_q, sy_q, sz_q;
  logic signed [31:0] lx_q, hx_q, ly_q, hy_q;
  logic signed [31:0] mz_q, mx_q, my_q;
  logic signed [16:0] diff;
  logic signed [57:0] ex, ey;
  logic div_busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; f_q <= '0; t_q <= '0; mind_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCx:   cx_q <= cfg_data_i;
        CfgCy:   cy_q <= cfg_data_i;
        CfgF:    f_q <= cfg_data_i;
        CfgT:    t_q <= cfg_data_i;
        CfgMind: mind_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign diff = 17'(d_q) - 17'(mind_q);
  assign stat_o.qualify = (17'(d_q) > DispFloor) && (diff > DispFloor) && (cnt_q != '1);
  assign stat_o.enough = cnt_q > CountBits'(MinPoints);
  assign stat_o.div_busy = div_busy;

  assign du = $signed({2'b00, u_q, 4'b0000}) - $signed({2'b00, cx_q});
  assign dv = $signed({2'b00, v_q, 4'b0000}) - $signed({2'b00, cy_q});

  // Divider operand select.
  always_comb begin
    num = '0; den = '0;
    case (ctrl_i.cmd)
      CmdDivX, CmdDivY, CmdDivZ: begin
        num = {{(DivBits-39){prod_q[34]}}, prod_q, 4'b0000}; den = DivBits'(d_q);
      end
      CmdMeanZ: begin num = sz_q; den = DivBits'({1'b0, cnt_q}); end
      CmdMeanX: begin num = sx_q; den = DivBits'({1'b0, cnt_q}); end
      CmdMeanY: begin num = sy_q; den = DivBits'({1'b0, cnt_q}); end
      default: ;
    endcase
  end

  srps_divider u_div (
    .clk_i, .rst_ni, .start_i(ctrl_i.div_start), .num_i(num), .den_i(den),
    .busy_o(div_busy), .quot_o(quot)
  );

  function automatic logic signed [SumBits-1:0] sadd(input logic signed [SumBits-1:0] a,
                                                     input logic signed [31:0] b);
    logic signed [SumBits:0] s;
    s = 57'(a) + 57'(b);
    if (s[SumBits] != s[SumBits-1]) return s[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                                     : {1'b0, {(SumBits-1){1'b1}}};
    return s[SumBits-1:0];
  endfunction

  // Accumulators; z is taken straight from the divider as its division ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0; sz_q <= '0;
      lx_q <= 32'sh7fffffff; hx_q <= 32'sh80000000;
      ly_q <= 32'sh7fffffff; hy_q <= 32'sh80000000;
    end else begin
      case (ctrl_i.cmd)
        CmdAccum: begin
          cnt_q <= cnt_q + 1'b1;
          sx_q <= sadd(sx_q, px_q); sy_q <= sadd(sy_q, py_q);
          sz_q <= sadd(sz_q, sat32(quot));
          if (px_q < lx_q) lx_q <= px_q;
          if (px_q > hx_q) hx_q <= px_q;
          if (py_q < ly_q) ly_q <= py_q;
          if (py_q > hy_q) hy_q <= py_q;
        end
        CmdClear: begin
          cnt_q <= '0; sx_q <= '0; sy_q <= '0; sz_q <= '0;
          lx_q <= 32'sh7fffffff; hx_q <= 32'sh80000000;
          ly_q <= 32'sh7fffffff; hy_q <= 32'sh80000000;
        end
        default: ;
      endcase
    end
  end

  // Product and quotient capture, one multiply per step.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CmdLoad: begin
        u_q <= pix_i[CoordBits-1:0]; v_q <= pix_i[12+CoordBits-1:12];
        d_q <= pix_i[39:24];
      end
      CmdDivX: prod_q <= 35'(du * $signed({1'b0, t_q}));
      CmdDivY: begin px_q <= sat32(quot); prod_q <= 35'(dv * $signed({1'b0, t_q})); end
      CmdDivZ: begin
        py_q <= sat32(quot); prod_q <= $signed({3'b000, 32'(f_q) * 32'(t_q)});
      end
      CmdMeanZ: ;
      CmdMeanX: mz_q <= sat32(quot);
      CmdMeanY: mx_q <= sat32(quot);
      CmdMeanEnd: my_q <= sat32(quot);
      default: ;
    endcase
  end

  assign ex = 58'(hx_q) - 58'(lx_q);
  assign ey = 58'(hy_q) - 58'(ly_q);
  assign res_o = {my_q, mx_q, mz_q, sat32(ey), sat32(ex)};
endmodule

### hw/rtl/srps_ctrl.sv
// Controller sequencing one pixel and the end-of-region result.
module srps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            last_i,
  input  logic            out_ready_i,
  input  srps_pkg::stat_t stat_i,
  output srps_pkg::ctrl_t ctrl_o,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            out_ok_o,
  output logic            snap_o
);
  import srps_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StCheck, StDivX, StDivY, StDivZ, StWait, StMeanZ, StMeanX, StMeanY,
    StClear, StOut
  } state_e;

  state_e state_q;
  logic last_q, ok_q, outv_q, started_q;
  state_e after_wait;

  // Divide steps: issue on entry, then wait for the divider to finish.
  always_comb begin
    ctrl_o = '{cmd: CmdNone, div_start: 1'b0};
    snap_o = 1'b0;
    case (state_q)
      StIdle:  if (in_fire_i) ctrl_o.cmd = CmdLoad;
      StCheck: if (stat_i.qualify) ctrl_o.cmd = CmdDivX;
      StDivX:  if (!started_q) ctrl_o = '{cmd: CmdDivX, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdDivY;
      StDivY:  if (!started_q) ctrl_o = '{cmd: CmdDivY, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdDivZ;
      StDivZ:  if (!started_q) ctrl_o = '{cmd: CmdDivZ, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdAccum;
      StMeanZ: if (!started_q) ctrl_o = '{cmd: CmdMeanZ, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdMeanX;
      StMeanX: if (!started_q) ctrl_o = '{cmd: CmdMeanX, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdMeanY;
      StMeanY: if (!started_q) ctrl_o = '{cmd: CmdMeanY, div_start: 1'b1};
               else if (!stat_i.div_busy) ctrl_o.cmd = CmdMeanEnd;
      StClear: begin
        ctrl_o.cmd = CmdClear; snap_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign after_wait = StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; last_q <= 1'b0; ok_q <= 1'b0; outv_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      case (state_q)
        StIdle: if (in_fire_i) begin last_q <= last_i; state_q <= StCheck; end
        StCheck: begin
          started_q <= 1'b0;
          if (stat_i.qualify) state_q <= StDivX;
          else state_q <= StWait;
        end
        StDivX: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StDivY; end
        end
        StDivY: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StDivZ; end
        end
        StDivZ: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StWait; end
        end
        StWait: begin
          // Results are emitted only once the previous one was taken.
          if (!last_q) state_q <= after_wait;
          else if (!outv_q || out_ready_i) begin
            ok_q <= stat_i.enough;
            state_q <= stat_i.enough ? StMeanZ : StClear;
          end
        end
        StMeanZ: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StMeanX; end
        end
        StMeanX: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StMeanY; end
        end
        StMeanY: begin
          if (!started_q) started_q <= 1'b1;
          else if (!stat_i.div_busy) begin started_q <= 1'b0; state_q <= StClear; end
        end
        StClear: state_q <= StOut;
        StOut: begin outv_q <= 1'b1; state_q <= StIdle; end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = outv_q;
  assign out_ok_o    = ok_q;
endmodule

### tb/testbench.sv
// Self-checking testbench for the stereo ROI point statistics block.
`timescale 1ns / 1ps

module testbench;
  import srps_pkg::*;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic signed [15:0] disparity;
    logic last_pixel;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] extent_x;
    logic signed [31:0] extent_y;
    logic signed [31:0] mean_z;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic valid_res;
  } stats_t;

  // One directed row: a pixel, plus an optional typed-in expectation.
  typedef struct {
    pixel_t px;
    bit     has_exp;
    stats_t exp;
  } row_t;

  localparam longint SumMax = 64'sd36028797018963967;
  localparam longint SumMin = -SumMax - 1;
  localparam int CountMax = (1 << CountBits) - 1;
  localparam int TimeoutCycles = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;

  stereo_roi_point_statistics_top i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of configuration and accumulators.
  longint cx, cy, fl, bl, mind;
  longint n_pts, acc_x, acc_y, acc_z;
  longint lo_x, hi_x, lo_y, hi_y;
  stats_t expected_stats[$];
  int errors = 0, results_seen = 0, valid_seen = 0, pixels_sent = 0;
  int cycle = 0;
  bit rx_hold = 1'b0, no_idle = 1'b0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip56(longint v);
    if (v > SumMax) return SumMax;
    if (v < SumMin) return SumMin;
    return v;
  endfunction

  task automatic clear_stats();
    n_pts = 0; acc_x = 0; acc_y = 0; acc_z = 0;
    lo_x = 64'sd2147483647; hi_x = -64'sd2147483648;
    lo_y = 64'sd2147483647; hi_y = -64'sd2147483648;
  endtask

  // Reproject one pixel, accumulate, and queue a result on the last pixel.
  task automatic predict_pixel(pixel_t p);
    longint d, px, py, pz;
    stats_t r;
    d = longint'(p.disparity);
    if (d > 32 && (d - mind) > 32 && n_pts < CountMax) begin
      px = clip32(((longint'(p.column) * 16 - cx) * bl * 16) / d);
      py = clip32(((longint'(p.row) * 16 - cy) * bl * 16) / d);
      pz = clip32((fl * bl * 16) / d);
      n_pts++;
      acc_x = clip56(acc_x + px);
      acc_y = clip56(acc_y + py);
      acc_z = clip56(acc_z + pz);
      if (px < lo_x) lo_x = px;
      if (px > hi_x) hi_x = px;
      if (py < lo_y) lo_y = py;
      if (py > hi_y) hi_y = py;
    end
    if (p.last_pixel) begin
      r = '0;
      if (n_pts > 10) begin
        r.extent_x = 32'(clip32(hi_x - lo_x));
        r.extent_y = 32'(clip32(hi_y - lo_y));
        r.mean_z = 32'(clip32(acc_z / n_pts));
        r.mean_x = 32'(clip32(acc_x / n_pts));
        r.mean_y = 32'(clip32(acc_y / n_pts));
        r.valid_res = 1'b1;
      end
      expected_stats.insert(expected_stats.size(), r);
      clear_stats();
    end
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgCx:   cx = val;
      CfgCy:   cy = val;
      CfgF:    fl = val;
      CfgT:    bl = val;
      CfgMind: mind = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [15:0] c_x, logic [15:0] c_y, logic [15:0] f,
                            logic [15:0] t, logic [15:0] md);
    write_reg(CfgCx, c_x); write_reg(CfgCy, c_y); write_reg(CfgF, f);
    write_reg(CfgT, t); write_reg(CfgMind, md);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one pixel with random gaps and wait for its transaction.
  task automatic send_pixel(pixel_t p);
    while (!no_idle && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.disparity, p.row, p.column};
    s_axis_tlast <= p.last_pixel;
    predict_pixel(p);
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  // Wait until every result has come back, plus the block's worst latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel(bit good, bit last);
    pixel_t p;
    p.column = 12'($urandom); p.row = 12'($urandom);
    p.disparity = good ? 16'($urandom_range(33, 32767)) : 16'($urandom);
    p.last_pixel = last;
    return p;
  endfunction

  // Receiver: random stalls, and a long hold-off on request.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // Result checker.
  always @(posedge clk_i) begin
    stats_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tdata[159:128], m_axis_tdata[160]};
      results_seen++;
      if (got.valid_res) valid_seen++;
      if (expected_stats.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (got.extent_x !== want.extent_x) begin
          $error("extent_x expected %0d actual %0d", want.extent_x, got.extent_x); errors++;
        end
        if (got.extent_y !== want.extent_y) begin
          $error("extent_y expected %0d actual %0d", want.extent_y, got.extent_y); errors++;
        end
        if (got.mean_z !== want.mean_z) begin
          $error("mean_z expected %0d actual %0d", want.mean_z, got.mean_z); errors++;
        end
        if (got.mean_x !== want.mean_x) begin
          $error("mean_x expected %0d actual %0d", want.mean_x, got.mean_x); errors++;
        end
        if (got.mean_y !== want.mean_y) begin
          $error("mean_y expected %0d actual %0d", want.mean_y, got.mean_y); errors++;
        end
        if (got.valid_res !== want.valid_res) begin
          $error("valid_res expected %0d actual %0d", want.valid_res, got.valid_res); errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycle > TimeoutCycles) begin
      $display("timeout after %0d cycles", cycle);
      $display("*** FAILED ***");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(int u, int v, int d, bit last);
    row_t r;
    r.px = '{column: 12'(u), row: 12'(v), disparity: 16'(d), last_pixel: last};
    r.has_exp = last;
    r.exp = '0;
    return r;
  endfunction

  initial begin
    int regions, len;
    cx = 0; cy = 0; fl = 0; bl = 0; mind = 0;
    clear_stats();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: zero registers give zero points, too few points give zeros.
    dir_rows = {dir_rows, mk(4095, 4095, 32767, 1)};
    // Disparity at the threshold, negative, and most negative never qualify.
    dir_rows = {dir_rows, mk(0, 0, 32, 0)};
    dir_rows = {dir_rows, mk(0, 0, -1, 0)};
    dir_rows = {dir_rows, mk(0, 0, -32768, 1)};
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px);
      // Rows with a typed-in result are checked against that value.
      if (dir_rows[i].has_exp)
        expected_stats[expected_stats.size() - 1] = dir_rows[i].exp;
    end
    drain();

    // Extremes of the camera: saturating points, extents and means.
    set_camera(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h8000);
    for (int i = 0; i < 12; i++)
      send_pixel('{column: (i[0] ? 12'hfff : 12'h000), row: 12'(i * 300),
                   disparity: (i < 6 ? 16'sd33 : 16'sd32767), last_pixel: (i == 11)});
    // A region with exactly ten points is too few.
    for (int i = 0; i < 10; i++)
      send_pixel('{column: 12'(i), row: 12'(i), disparity: 16'sd100,
                   last_pixel: (i == 9)});
    drain();

    // min_disparity at the top: nothing qualifies.
    set_camera(16'h8000, 16'h4000, 16'h1000, 16'h1000, 16'h7fff);
    for (int i = 0; i < 11; i++) send_pixel(rand_pixel(1, i == 10));
    drain();

    // Random phases with several camera settings; long hold-off in one.
    for (int ph = 0; ph < 4; ph++) begin
      set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom));
      no_idle = (ph == 2);
      if (ph == 1) begin
        fork
          begin rx_hold = 1'b1; repeat (3000) @(posedge clk_i); rx_hold = 1'b0; end
        join_none
      end
      regions = 0;
      while (pixels_sent < 140 * (ph + 1) + 20) begin
        len = $urandom_range(1, 4) == 1 ? $urandom_range(1, 12) : $urandom_range(11, 30);
        for (int k = 0; k < len; k++)
          send_pixel(rand_pixel($urandom_range(99) < 85, k == len - 1));
        regions++;
      end
      drain();
    end
    no_idle = 1'b0;

    $display("Sent %0d pixels; checked %0d region results, %0d of them valid.",
             pixels_sent, results_seen, valid_seen);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
